### rtl/wcra_pkg.sv
`default_nettype none
package wcra_pkg;

	localparam int HIST_DEPTH = 32;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);
	localparam int TIME_W     = 32;
	localparam int ALT_W      = 28;
	localparam int RATE_W     = 21;
	localparam int WIN_W      = 22;
	localparam int NUM_W      = 39;
	localparam int SLOT_W     = TIME_W + ALT_W;
	localparam int PADDR_W    = 4;

	localparam logic [RATE_W-2:0] RATE_LIMIT = 20'd1000000;

	// register indexes
	localparam logic [1:0] REG_WINDOW  = 2'd0;
	localparam logic [1:0] REG_MIN_INT = 2'd1;
	localparam logic [1:0] REG_MAX_GAP = 2'd2;
	localparam logic [1:0] REG_MAX_AGE = 2'd3;

	// sample actions
	localparam logic [1:0] ACT_IGNORED  = 2'd0;
	localparam logic [1:0] ACT_APPENDED = 2'd1;
	localparam logic [1:0] ACT_REPLACED = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NEWEST,
		ST_SCAN,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage
`default_nettype wire

### rtl/wcra_if.sv
`default_nettype none
interface wcra_in_if import wcra_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic              time_valid;
	logic [TIME_W-1:0] time_ms;
	logic signed [ALT_W-1:0] altitude_mm;

	modport source (output valid, mode, time_valid, time_ms, altitude_mm, input ready);
	modport sink (input valid, mode, time_valid, time_ms, altitude_mm, output ready);
endinterface

interface wcra_out_if import wcra_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [RATE_W-1:0] climb_rate_mm_s;
	logic [TIME_W-1:0]        span_ms;
	logic [1:0]               slot_action;
	logic                     history_cleared;
	logic                     expired;

	modport source (output valid, climb_rate_mm_s, span_ms, slot_action, history_cleared,
		expired, input ready);
	modport sink (input valid, climb_rate_mm_s, span_ms, slot_action, history_cleared,
		expired, output ready);
endinterface
`default_nettype wire

### rtl/windowed_climb_rate_averager.sv
// Windowed climb-rate averager.
// sample channel: one item per altitude sample (mode 0) or expiry query (mode 1),
// valid/ready handshake, accepted when both are high.
// result channel: exactly one item per accepted sample item, in order.
// APB port: window, min interval, max gap and max age at byte addresses 0, 4, 8, 12;
// write only while the block is idle; pready is always high.
// A query or an invalid-time sample goes from acceptance straight to the result. A valid
// sample reads the newest slot, scans all 32 ring slots through the one-read-port slot
// memory, forms the scaled altitude difference and then, unless the oldest in-window slot
// is the newest one or the span is zero, runs a bit-serial divider before its result.
// One item is in work at a time; sample.ready is high only while idle, from the cycle
// after the result is registered.
// A finished result sits in the output register while the next item is accepted;
// if the receiver stalls the block waits with its next result until the register frees.
// Reset: history empty, no last update, registers at their defaults; the slot
// memory needs no clearing since per-slot valid bits are cleared at once.
`default_nettype none
module windowed_climb_rate_averager import wcra_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	wcra_in_if.sink                 sample,
	wcra_out_if.source              result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);
	state_t state_q, state_d;

	logic [WIN_W-1:0]  window_q;
	logic [TIME_W-1:0] min_int_q, max_gap_q, max_age_q;

	logic              mode_q, tv_q;
	logic [TIME_W-1:0] t_q;
	logic [ALT_W-1:0]  alt_q;

	logic [HIST_DEPTH-1:0] slot_valid_q;
	logic [HIST_AW-1:0]    newest_q;
	logic                  empty_q;
	logic [TIME_W-1:0]     lu_q;
	logic                  luv_q;

	logic [TIME_W-1:0] best_time_q;
	logic [ALT_W-1:0]  best_alt_q;
	logic [HIST_AW-1:0] best_idx_q;
	logic [HIST_AW:0]  scan_q;
	logic              pend_s1;
	logic [HIST_AW-1:0] idx_s1;

	logic              neg_q;
	logic [TIME_W-1:0] span_q;

	logic signed [RATE_W-1:0] res_rate_q;
	logic [1:0]        res_act_q;
	logic              res_clr_q, res_exp_q;

	logic              out_valid_q;
	logic signed [RATE_W-1:0] out_rate_q;
	logic [TIME_W-1:0] out_span_q;
	logic [1:0]        out_act_q;
	logic              out_clr_q, out_exp_q;

	logic              accept, cfg_wr;
	logic              ram_we;
	logic [HIST_AW-1:0] ram_waddr, ram_raddr;
	logic [SLOT_W-1:0] ram_rdata;
	logic [TIME_W-1:0] r_time;
	logic [ALT_W-1:0]  r_alt;

	logic              newest_live, do_replace, do_append, do_write;
	logic [HIST_AW-1:0] next_slot, new_newest;
	logic              in_window, older;
	logic [TIME_W-1:0] span_now;
	logic signed [ALT_W:0] diff;
	logic [ALT_W:0]    mag;
	logic [NUM_W-1:0]  prod;
	logic              div_start, div_done;
	logic [NUM_W-1:0]  quo;
	logic [RATE_W-2:0] sat;
	logic              out_free;

	assign accept   = sample.valid && sample.ready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign out_free = !out_valid_q || result.ready;
	assign sample.ready = (state_q == ST_IDLE);

	// configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= WIN_W'(30000);
			min_int_q <= '0;
			max_gap_q <= '1;
			max_age_q <= TIME_W'(10000);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_WINDOW:  window_q  <= pwdata[WIN_W-1:0];
				REG_MIN_INT: min_int_q <= pwdata;
				REG_MAX_GAP: max_gap_q <= pwdata;
				REG_MAX_AGE: max_age_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WINDOW:  prdata = {{(32-WIN_W){1'b0}}, window_q};
			REG_MIN_INT: prdata = min_int_q;
			REG_MAX_GAP: prdata = max_gap_q;
			REG_MAX_AGE: prdata = max_age_q;
			default:     prdata = '0;
		endcase
	end

	// slot memory: time and altitude per ring entry
	assign r_time    = ram_rdata[SLOT_W-1:ALT_W];
	assign r_alt     = ram_rdata[ALT_W-1:0];
	assign ram_raddr = (state_q == ST_SCAN) ? scan_q[HIST_AW-1:0] : newest_q;

	wcra_ram #(.WIDTH(SLOT_W), .DEPTH(HIST_DEPTH)) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({t_q, alt_q}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// append / replace decision against the newest slot
	assign newest_live = !empty_q && slot_valid_q[newest_q];
	assign do_replace  = newest_live && (t_q == r_time);
	assign do_append   = !newest_live ||
		(!do_replace && ({1'b0, t_q} >= {1'b0, r_time} + {1'b0, min_int_q}));
	assign do_write    = do_append || do_replace;
	assign next_slot   = (newest_q == HIST_AW'(HIST_DEPTH - 1)) ? '0 : newest_q + 1'b1;
	assign new_newest  = do_append ? (empty_q ? '0 : next_slot) : newest_q;
	assign ram_we      = (state_q == ST_NEWEST) && do_write;
	assign ram_waddr   = new_newest;

	// window scan compare on the slot read last cycle
	assign in_window = ({1'b0, r_time} + {{(TIME_W-WIN_W+1){1'b0}}, window_q}) >= {1'b0, t_q};
	assign older     = r_time < best_time_q;

	// rate numerator and divider
	assign span_now  = t_q - best_time_q;
	assign diff      = $signed({alt_q[ALT_W-1], alt_q}) - $signed({best_alt_q[ALT_W-1], best_alt_q});
	assign mag       = diff[ALT_W] ? (ALT_W+1)'(-diff) : diff;
	assign prod      = NUM_W'(mag) * NUM_W'(1000);
	assign div_start = (state_q == ST_MUL) && (best_idx_q != newest_q) && (span_now != '0);

	wcra_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod),
		.divisor  (span_now),
		.done     (div_done),
		.quotient (quo)
	);

	assign sat = (quo > NUM_W'(RATE_LIMIT)) ? RATE_LIMIT : quo[RATE_W-2:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = (sample.mode || !sample.time_valid) ? ST_DONE : ST_NEWEST;
			end
			ST_NEWEST: state_d = ST_SCAN;
			ST_SCAN: begin
				if (scan_q == (HIST_AW+1)'(HIST_DEPTH) && !pend_s1) state_d = ST_MUL;
			end
			ST_MUL:  state_d = div_start ? ST_DIV : ST_DONE;
			ST_DIV:  if (div_done) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// history control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			newest_q     <= '0;
			empty_q      <= 1'b1;
			lu_q         <= '0;
			luv_q        <= 1'b0;
			scan_q       <= '0;
			pend_s1      <= 1'b0;
		end else begin
			if (accept && !sample.mode) begin
				if (!sample.time_valid || (luv_q && (sample.time_ms < lu_q ||
					{1'b0, sample.time_ms} > {1'b0, lu_q} + {1'b0, max_gap_q}))) begin
					slot_valid_q <= '0;
					newest_q     <= '0;
					empty_q      <= 1'b1;
				end
				luv_q <= sample.time_valid;
				if (sample.time_valid) begin
					lu_q <= sample.time_ms;
				end
			end
			if (state_q == ST_NEWEST) begin
				newest_q <= new_newest;
				if (do_write) begin
					empty_q <= 1'b0;
					slot_valid_q[new_newest] <= 1'b1;
				end
				scan_q  <= '0;
				pend_s1 <= 1'b0;
			end
			if (state_q == ST_SCAN) begin
				pend_s1 <= (scan_q != (HIST_AW+1)'(HIST_DEPTH));
				if (scan_q != (HIST_AW+1)'(HIST_DEPTH)) scan_q <= scan_q + 1'b1;
			end
		end
	end

	// item payload and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q     <= sample.mode;
			tv_q       <= sample.time_valid;
			t_q        <= sample.time_ms;
			alt_q      <= sample.altitude_mm;
			res_rate_q <= '0;
			res_act_q  <= ACT_IGNORED;
			res_clr_q  <= !sample.mode && (!sample.time_valid || (luv_q &&
				(sample.time_ms < lu_q ||
				{1'b0, sample.time_ms} > {1'b0, lu_q} + {1'b0, max_gap_q})));
			res_exp_q  <= sample.mode && (!luv_q || sample.time_ms < lu_q ||
				{1'b0, sample.time_ms} > {1'b0, lu_q} + {1'b0, max_age_q});
			span_q     <= '0;
		end
		if (state_q == ST_NEWEST) begin
			best_time_q <= do_write ? t_q : r_time;
			best_alt_q  <= do_write ? alt_q : r_alt;
			best_idx_q  <= new_newest;
			res_act_q   <= do_append ? ACT_APPENDED : (do_replace ? ACT_REPLACED : ACT_IGNORED);
		end
		if (state_q == ST_SCAN) begin
			idx_s1 <= scan_q[HIST_AW-1:0];
			if (pend_s1 && slot_valid_q[idx_s1] && in_window && older) begin
				best_time_q <= r_time;
				best_alt_q  <= r_alt;
				best_idx_q  <= idx_s1;
			end
		end
		if (state_q == ST_MUL) begin
			span_q <= span_now;
			neg_q  <= diff[ALT_W];
		end
		if (div_done) begin
			res_rate_q <= neg_q ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_rate_q <= (mode_q || !tv_q) ? '0 : res_rate_q;
			out_span_q <= span_q;
			out_act_q  <= res_act_q;
			out_clr_q  <= res_clr_q;
			out_exp_q  <= res_exp_q;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.climb_rate_mm_s = out_rate_q;
	assign result.span_ms         = out_span_q;
	assign result.slot_action     = out_act_q;
	assign result.history_cleared = out_clr_q;
	assign result.expired         = out_exp_q;
endmodule
`default_nettype wire

### rtl/wcra_ram.sv
`default_nettype none
module wcra_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### rtl/wcra_div.sv
`default_nettype none
module wcra_div import wcra_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [NUM_W-1:0]  dividend,
	input  wire logic [TIME_W-1:0] divisor,
	output logic                   done,
	output logic [NUM_W-1:0]       quotient
);
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [TIME_W-1:0] div_q;
	logic [TIME_W-1:0] rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [TIME_W:0]   shifted;
	logic              fits;

	// one quotient bit per cycle, restoring
	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign fits    = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? TIME_W'(shifted - {1'b0, div_q}) : shifted[TIME_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

### rtl/wcra_checker.sv
`default_nettype none
module wcra_checker import wcra_pkg::*; (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_valid,
	input wire logic                     in_ready,
	input wire logic                     out_valid,
	input wire logic                     out_ready,
	input wire logic signed [RATE_W-1:0] climb,
	input wire logic [TIME_W-1:0]        span,
	input wire logic [1:0]               action,
	input wire logic                     cleared,
	input wire logic                     expired
);
	// result held while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(climb) && $stable(span))
		else $error("result dropped or changed while stalled");

	// one item in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while busy");

	// an expired flag comes only with an otherwise empty result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && expired |-> climb == '0 && span == '0 && action == ACT_IGNORED && !cleared)
		else $error("query result carries sample fields");

	// rate stays within its saturation bounds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> climb <= $signed(RATE_W'(1000000)) && climb >= -$signed(RATE_W'(1000000)))
		else $error("climb rate out of range");
endmodule

bind windowed_climb_rate_averager wcra_checker u_wcra_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.climb     (result.climb_rate_mm_s),
	.span      (result.span_ms),
	.action    (result.slot_action),
	.cleared   (result.history_cleared),
	.expired   (result.expired)
);
`default_nettype wire

### tb/windowed_climb_rate_averager_test.sv
`timescale 1ns / 100ps
`default_nettype none
module windowed_climb_rate_averager_test;
	import wcra_pkg::*;

	// expected result of one item
	typedef struct {
		logic signed [RATE_W-1:0] rate;
		logic [TIME_W-1:0]        span;
		logic [1:0]               action;
		logic                     cleared;
		logic                     expired;
	} climb_result_t;

	// behavioral copy of the averager plus the queue of pending results
	class climb_scoreboard;
		bit                    occupied[HIST_DEPTH];
		logic [TIME_W-1:0]     stamp[HIST_DEPTH];
		logic signed [ALT_W-1:0] height[HIST_DEPTH];
		int unsigned           head;
		bit                    empty;
		logic [TIME_W-1:0]     last_t;
		bit                    last_ok;
		logic [WIN_W-1:0]      window;
		logic [31:0]           min_int, max_gap, max_age;
		climb_result_t         pending[$];
		int                    mismatches;
		int                    checked;

		function void wipe();
			foreach (occupied[i]) occupied[i] = 0;
			head = 0;
			empty = 1;
			last_ok = 0;
		endfunction

		function void init();
			wipe();
			last_t = 0;
			window = 30000;
			min_int = 0;
			max_gap = 32'hFFFFFFFF;
			max_age = 10000;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] v);
			case (idx)
				REG_WINDOW: window = v[WIN_W-1:0];
				REG_MIN_INT: min_int = v;
				REG_MAX_GAP: max_gap = v;
				REG_MAX_AGE: max_age = v;
				default: ;
			endcase
		endfunction

		// predict the result of one accepted item
		function void note_item(bit md, bit tv, logic [31:0] t, logic signed [ALT_W-1:0] alt);
			climb_result_t r;
			bit have, rep, app;
			int unsigned best;
			longint diff, q;
			r = '{default: 0};
			if (md) begin
				r.expired = !last_ok || t < last_t || {1'b0, t} > {1'b0, last_t} + {1'b0, max_age};
			end else if (!tv) begin
				wipe();
				r.cleared = 1;
			end else begin
				if (last_ok && (t < last_t || {1'b0, t} > {1'b0, last_t} + {1'b0, max_gap})) begin
					wipe();
					r.cleared = 1;
				end
				last_t = t;
				last_ok = 1;
				have = !empty && occupied[head];
				rep = have && t == stamp[head];
				app = !have || (!rep && {1'b0, t} >= {1'b0, stamp[head]} + {1'b0, min_int});
				r.action = app ? ACT_APPENDED : (rep ? ACT_REPLACED : ACT_IGNORED);
				if (app) begin
					head = empty ? 0 : (head + 1) % HIST_DEPTH;
					empty = 0;
				end
				if (app || rep) begin
					occupied[head] = 1;
					stamp[head] = t;
					height[head] = alt;
				end
				best = head;
				for (int i = 0; i < HIST_DEPTH; i++) begin
					if (!occupied[i]) continue;
					if ({1'b0, stamp[i]} + {11'b0, window} < {1'b0, t}) continue;
					if (stamp[i] < stamp[best]) best = i;
				end
				r.span = t - stamp[best];
				if (best != head && r.span != 0) begin
					diff = longint'(alt) - longint'(height[best]);
					q = (diff * 1000) / longint'({32'b0, r.span});
					if (q > 1000000) q = 1000000;
					if (q < -1000000) q = -1000000;
					r.rate = q[RATE_W-1:0];
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(climb_result_t a);
			climb_result_t e;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result item rate %0d", a.rate);
				return;
			end
			e = pending.pop_front();
			if (a.rate !== e.rate || a.span !== e.span || a.action !== e.action ||
					a.cleared !== e.cleared || a.expired !== e.expired) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: exp rate %0d span %0d act %0d clr %0b exp %0b,",
						" got rate %0d span %0d act %0d clr %0b exp %0b"},
						e.rate, e.span, e.action, e.cleared, e.expired,
						a.rate, a.span, a.action, a.cleared, a.expired);
			end
		endfunction
	endclass

	localparam int WATCHDOG = 20000;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [PADDR_W-1:0] paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic pready;

	wcra_in_if sample_ch ();
	wcra_out_if result_ch ();

	windowed_climb_rate_averager dut (
		.clk(clk), .arst_n(arst_n), .sample(sample_ch.sink), .result(result_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	climb_scoreboard board = new();
	int idle_cycles = 0;
	int items_sent = 0;
	bit stall_on = 0;
	logic [31:0] t_now = 0;

	initial begin
		sample_ch.valid = 0;
		sample_ch.mode = 0;
		sample_ch.time_valid = 0;
		sample_ch.time_ms = 0;
		sample_ch.altitude_mm = 0;
		result_ch.ready = 0;
	end

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// receiver stall pattern and result checking
	always @(posedge clk) begin
		climb_result_t got;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				got.rate = result_ch.climb_rate_mm_s;
				got.span = result_ch.span_ms;
				got.action = result_ch.slot_action;
				got.cleared = result_ch.history_cleared;
				got.expired = result_ch.expired;
				board.check_result(got);
			end
			if ((result_ch.valid && result_ch.ready) || (sample_ch.valid && sample_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if ($urandom_range(0, 63) == 0) stall_on <= !stall_on;
			result_ch.ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog expired with %0d results outstanding", board.pending.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] v);
		@(posedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		board.set_reg(idx, v);
	endtask

	task automatic write_all(logic [31:0] w, logic [31:0] mi, logic [31:0] mg, logic [31:0] ma);
		write_reg(REG_WINDOW, w);
		write_reg(REG_MIN_INT, mi);
		write_reg(REG_MAX_GAP, mg);
		write_reg(REG_MAX_AGE, ma);
	endtask

	// one item: holds valid until accepted, leaves it high for back-to-back
	task automatic send_item(bit md, bit tv, logic [31:0] t, logic signed [ALT_W-1:0] alt,
			bit keep);
		sample_ch.valid <= 1;
		sample_ch.mode <= md;
		sample_ch.time_valid <= tv;
		sample_ch.time_ms <= t;
		sample_ch.altitude_mm <= alt;
		do @(posedge clk); while (!sample_ch.ready);
		board.note_item(md, tv, t, alt);
		items_sent++;
		if (!keep) begin
			sample_ch.valid <= 0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic signed [ALT_W-1:0] rand_alt();
		case ($urandom_range(0, 5))
			0: return -28'sd1000000;
			1: return 28'sd100000000;
			2: return ALT_W'($urandom);
			default: return $signed(28'($urandom_range(0, 200000))) - 28'sd100000;
		endcase
	endfunction

	// random phase: bursts of mostly forward-moving samples
	task automatic random_phase(int n, int step_max);
		int burst;
		logic [31:0] t;
		bit md, tv;
		burst = 0;
		for (int k = 0; k < n; k++) begin
			if (burst == 0) begin
				repeat ($urandom_range(0, 6)) @(posedge clk);
				burst = $urandom_range(1, 12);
			end
			burst--;
			md = ($urandom_range(0, 9) == 0);
			tv = ($urandom_range(0, 39) != 0);
			case ($urandom_range(0, 19))
				0: t = $urandom;
				1: t = t_now - $urandom_range(1, 100);
				2: t = t_now;
				default: t = t_now + $urandom_range(0, step_max);
			endcase
			if (!md && tv) t_now = t;
			send_item(md, tv, t, rand_alt(), burst != 0);
		end
		sample_ch.valid <= 0;
	endtask

	initial begin
		board.init();
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: defaults, extremes, every action and clear path
		send_item(1, 0, 0, 0, 0);
		send_item(0, 1, 0, -28'sd1000000, 0);
		send_item(0, 1, 0, 28'sd100000000, 0);
		send_item(0, 1, 1, 28'sd100000000, 0);
		send_item(0, 1, 1000, -28'sd1000000, 0);
		send_item(1, 0, 5000, 0, 0);
		send_item(1, 1, 20000, 0, 0);
		send_item(1, 1, 500, 0, 0);
		send_item(0, 1, 900, 0, 0);
		send_item(0, 0, 2000, 5, 0);
		send_item(0, 1, 32'hFFFFFFFF, 28'sh7FFFFFF, 0);
		send_item(0, 1, 32'hFFFFFFFF, 28'sh8000000, 0);
		send_item(1, 0, 32'hFFFFFFFF, 0, 0);
		drain();
		write_all(0, 32'hFFFFFFFF, 1, 0);
		send_item(0, 1, 100, 10, 0);
		send_item(0, 1, 100, 20, 0);
		send_item(0, 1, 101, 30, 0);
		send_item(0, 1, 103, 30, 0);
		send_item(1, 1, 103, 0, 0);
		send_item(1, 1, 104, 0, 0);
		drain();
		write_all(3600000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_item(0, 1, 0, 0, 0);
		send_item(0, 1, 32'hFFFFFFFF, 1, 0);
		send_item(1, 1, 32'hFFFFFFFF, 0, 0);
		drain();

		// random phases over several register settings
		write_all(30000, 0, 32'hFFFFFFFF, 10000);
		random_phase(300, 3000);
		drain();
		write_all(1, 0, 5000, 1);
		random_phase(250, 40);
		drain();
		write_all(5000, 300, 4000, 2000);
		random_phase(300, 800);
		drain();
		write_all(3600000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		random_phase(100, 100000);
		drain();
		write_all($urandom_range(1, 3600000), $urandom_range(0, 50), $urandom, $urandom);
		random_phase(400, 600);
		drain();

		$display("sent %0d items over directed and random register settings, checked %0d results",
			items_sent, board.checked);
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("Test completed successfully");
		else begin
			$display("%0d mismatches, %0d results missing", board.mismatches,
				board.pending.size());
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
`default_nettype wire

### filelist.f
rtl/wcra_pkg.sv
rtl/wcra_if.sv
rtl/wcra_ram.sv
rtl/wcra_div.sv
rtl/windowed_climb_rate_averager.sv
rtl/wcra_checker.sv
tb/windowed_climb_rate_averager_test.sv
